### rtl/core/esc_pkg.sv
// Shared types and constants of the environmental sensor compensation block.
package esc_pkg;

	localparam int RAW_P_W   = 20;
	localparam int RAW_T_W   = 20;
	localparam int RAW_H_W   = 16;
	localparam int TEMP_W    = 16;
	localparam int PRESS_W   = 32;
	localparam int HUM_W     = 17;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;

	localparam int NUM_MAG_W = 63;
	localparam int DEN_W     = 40;
	localparam int QUO_W     = 36;
	localparam int TRIAL_W   = DEN_W + QUO_W;
	localparam int DIV_STEPS = QUO_W;

	localparam logic signed [64:0] NUM_LIM   = 65'sd2951479051793528;
	localparam logic [QUO_W-1:0]   QUOT_LIM  = QUO_W'(64'd34359738368);
	localparam logic signed [33:0] HUM_MAX   = 34'sd419430400;
	localparam logic [HUM_W-1:0]   HUM_OUT_MAX = 17'd102400;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_TRIM    = 3'd0,
		REG_PRESS_TRIM_A = 3'd1,
		REG_PRESS_TRIM_B = 3'd2,
		REG_PRESS_TRIM_C = 3'd3,
		REG_HUM_TRIM     = 3'd4,
		REG_HUM_PRESENT  = 3'd5
	} esc_reg_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic [HUM_W-1:0]         hum;
		logic                     neg;
		logic                     dz;
		logic                     ovf;
	} esc_side_t;

endpackage

### rtl/core/esc_if.sv
// Sample and result channel interfaces of the compensation block.
interface esc_sample_if;
	import esc_pkg::*;
	logic               valid;
	logic               ready;
	logic [RAW_P_W-1:0] raw_pressure;
	logic [RAW_T_W-1:0] raw_temperature;
	logic [RAW_H_W-1:0] raw_humidity;
	modport source (output valid, raw_pressure, raw_temperature, raw_humidity, input ready);
	modport sink (input valid, raw_pressure, raw_temperature, raw_humidity, output ready);
endinterface

interface esc_result_if;
	import esc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temperature_centi;
	logic [PRESS_W-1:0]       pressure_q24_8;
	logic                     pressure_valid;
	logic [HUM_W-1:0]         humidity_q22_10;
	modport source (output valid, temperature_centi, pressure_q24_8, pressure_valid,
		humidity_q22_10, input ready);
	modport sink (input valid, temperature_centi, pressure_q24_8, pressure_valid,
		humidity_q22_10, output ready);
endinterface

### rtl/core/env_sensor_compensation.sv
// Top level of the environmental sensor compensation pipeline.
// Each raw sample word yields one result word, and a new sample is taken every cycle
// unless held. The depth is set by the pressure divide, a restoring divider that resolves
// one quotient bit per stage over 36 stages, with seven stages of trim products ahead of it
// and four stages of pressure correction behind it. A result word that is not taken holds
// the whole pipeline. Trim registers must be written while no sample is in flight.
module env_sensor_compensation (
	input  logic                          clk,
	input  logic                          arst_n,
	esc_sample_if.sink                    samp,
	esc_result_if.source                  res,
	input  logic                          cfg_wen,
	input  logic [esc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [esc_pkg::CFG_W-1:0]     cfg_data
);
	import esc_pkg::*;

	logic [47:0] temp_trim_q;
	logic [63:0] press_trim_a_q;
	logic [63:0] press_trim_b_q;
	logic [15:0] press_trim_c_q;
	logic [63:0] hum_trim_q;
	logic        hum_present_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_trim_q    <= '0;
			press_trim_a_q <= '0;
			press_trim_b_q <= '0;
			press_trim_c_q <= '0;
			hum_trim_q     <= '0;
			hum_present_q  <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_TEMP_TRIM:    temp_trim_q    <= cfg_data[47:0];
				REG_PRESS_TRIM_A: press_trim_a_q <= cfg_data;
				REG_PRESS_TRIM_B: press_trim_b_q <= cfg_data;
				REG_PRESS_TRIM_C: press_trim_c_q <= cfg_data[15:0];
				REG_HUM_TRIM:     hum_trim_q     <= cfg_data;
				REG_HUM_PRESENT:  hum_present_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic signed [16:0] t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
	logic signed [8:0]  h3;
	logic signed [11:0] h4, h5;
	logic signed [7:0]  h6;

	assign t1 = $signed({1'b0, temp_trim_q[15:0]});
	assign t2 = $signed(temp_trim_q[31:16]);
	assign t3 = $signed(temp_trim_q[47:32]);
	assign p1 = $signed({1'b0, press_trim_a_q[15:0]});
	assign p2 = $signed(press_trim_a_q[31:16]);
	assign p3 = $signed(press_trim_a_q[47:32]);
	assign p4 = $signed(press_trim_a_q[63:48]);
	assign p5 = $signed(press_trim_b_q[15:0]);
	assign p6 = $signed(press_trim_b_q[31:16]);
	assign p7 = $signed(press_trim_b_q[47:32]);
	assign p8 = $signed(press_trim_b_q[63:48]);
	assign p9 = $signed(press_trim_c_q);
	assign h2 = $signed(hum_trim_q[23:8]);
	assign h3 = $signed({1'b0, hum_trim_q[31:24]});
	assign h4 = $signed(hum_trim_q[43:32]);
	assign h5 = $signed(hum_trim_q[55:44]);
	assign h6 = $signed(hum_trim_q[63:56]);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic v_s44, v_s45, v_s46, v_s47;
	logic dv_v_sd [DIV_STEPS];

	assign adv        = !v_s47 || res.ready;
	assign samp.ready = adv;

	// Stage 1: first temperature products.
	logic signed [17:0] ta_diff;
	logic signed [33:0] ta_prod;
	logic signed [16:0] td;
	logic signed [33:0] td_sq;
	logic signed [22:0] t_va_s1;
	logic [31:0]        td_sq_s1;
	logic [RAW_P_W-1:0] raw_p_s1, raw_p_s2, raw_p_s3, raw_p_s4;
	logic [RAW_H_W-1:0] raw_h_s1, raw_h_s2;

	assign ta_diff = $signed({1'b0, samp.raw_temperature[19:3]})
		- $signed({1'b0, temp_trim_q[15:0], 1'b0});
	assign ta_prod = ta_diff * t2;
	assign td      = $signed({1'b0, samp.raw_temperature[19:4]}) - t1;
	assign td_sq   = td * td;

	// Stage 2: fine temperature.
	logic signed [20:0] tb_u;
	logic signed [36:0] tb_prod;
	logic signed [23:0] fine_s2;

	assign tb_u    = $signed({1'b0, td_sq_s1[31:12]});
	assign tb_prod = tb_u * t3;

	// Stage 3: temperature result, pressure and humidity first products.
	logic signed [26:0] tf5;
	logic signed [18:0] tq;
	logic signed [15:0] temp_c;
	logic signed [23:0] pva, hh;
	logic signed [47:0] pva_sq;
	logic signed [39:0] pv_p5, pv_p2;
	logic signed [35:0] h5_hh;
	logic signed [37:0] hx_sum;
	logic signed [31:0] hh_h6;
	logic signed [32:0] hh_h3;
	logic signed [15:0] temp_s3, temp_s4, temp_s5, temp_s6, temp_s7;
	logic [46:0]        pva_sq_s3;
	logic signed [39:0] pv_p5_s3, pv_p2_s3;
	logic signed [22:0] hx_s3, hx_s4, hx_s5;
	logic signed [21:0] hy1_s3;
	logic signed [22:0] hy2_s3;

	always_comb begin
		tf5 = fine_s2 * 27'sd5 + 27'sd128;
		tq  = $signed(tf5[26:8]);
		if (tq > 19'sd32767) begin
			temp_c = 16'sh7fff;
		end else if (tq < -19'sd32768) begin
			temp_c = -16'sh8000;
		end else begin
			temp_c = tq[15:0];
		end
	end

	assign pva    = fine_s2 - 24'sd128000;
	assign pva_sq = pva * pva;
	assign pv_p5  = pva * p5;
	assign pv_p2  = pva * p2;
	assign hh     = fine_s2 - 24'sd76800;
	assign h5_hh  = h5 * hh;
	assign hx_sum = $signed({8'b0, raw_h_s2, 14'b0}) - $signed({h4, 20'b0}) - h5_hh
		+ 38'sd16384;
	assign hh_h6  = hh * h6;
	assign hh_h3  = hh * h3;

	// Stage 4: pressure offset and divisor terms, humidity product.
	logic signed [63:0] pvb_p6, pva_p3;
	logic signed [63:0] pvb_s4;
	logic signed [57:0] pa_s4;
	logic signed [44:0] hy_prod;
	logic signed [34:0] hy_s4;

	assign pvb_p6  = $signed({1'b0, pva_sq_s3}) * p6;
	assign pva_p3  = $signed({1'b0, pva_sq_s3}) * p3;
	assign hy_prod = hy1_s3 * hy2_s3;

	// Stage 5: divisor and numerator, humidity gain.
	logic signed [74:0] pd_prod;
	logic [20:0]        pp;
	logic signed [64:0] pn;
	logic signed [52:0] pn_sat;
	logic signed [41:0] pd_s5;
	logic signed [52:0] pnum_s5;
	logic signed [35:0] hys;
	logic signed [51:0] hm;
	logic signed [37:0] hyy_s5;

	assign pd_prod = pa_s4 * p1;
	assign pp      = 21'h100000 - {1'b0, raw_p_s4};
	assign pn      = $signed({13'b0, pp, 31'b0}) - pvb_s4;
	assign hys     = hy_s4 + 36'sd2097152;
	assign hm      = hys * h2 + 52'sd8192;

	always_comb begin
		if (pn > NUM_LIM) begin
			pn_sat = NUM_LIM[52:0];
		end else if (pn < -NUM_LIM) begin
			pn_sat = -NUM_LIM[52:0];
		end else begin
			pn_sat = pn[52:0];
		end
	end

	// Stage 6: magnitudes for the divide, humidity product with saturation.
	logic signed [64:0]    nm, nm_abs;
	logic signed [41:0]    pd_abs;
	logic signed [60:0]    hxy;
	logic signed [31:0]    hc_sat;
	logic [NUM_MAG_W-1:0]  n_s6, n_s7;
	logic [DEN_W-1:0]      d_s6, d_s7;
	logic                  neg_s6, dz_s6, neg_s7, dz_s7;
	logic signed [31:0]    hc_s6, hc_s7;

	assign nm     = pnum_s5 * 65'sd3125;
	assign nm_abs = nm[64] ? -nm : nm;
	assign pd_abs = pd_s5[41] ? -pd_s5 : pd_s5;
	assign hxy    = hx_s5 * hyy_s5;

	always_comb begin
		if (hxy > 61'sd2147483647) begin
			hc_sat = 32'sh7fffffff;
		end else if (hxy < -61'sd2147483648) begin
			hc_sat = -32'sh80000000;
		end else begin
			hc_sat = hxy[31:0];
		end
	end

	// Stage 7: quotient range check, humidity square.
	logic               ovf;
	logic               ovf_s7;
	logic signed [16:0] ha;
	logic signed [33:0] haa;
	logic [32:0]        haa_s7;

	assign ovf = {{(TRIAL_W-NUM_MAG_W){1'b0}}, n_s6} >= {d_s6, {QUO_W{1'b0}}};
	assign ha  = $signed(hc_s6[31:15]);
	assign haa = ha * ha;

	// Humidity result is finished on the way into the divider.
	logic [33:0]        ht_prod;
	logic signed [33:0] hf;
	logic [HUM_W-1:0]   hum_c;
	esc_side_t          side_s7;

	assign ht_prod = haa_s7[32:7] * hum_trim_q[7:0];
	assign hf      = hc_s7 - $signed({1'b0, ht_prod[33:4]});

	always_comb begin
		if (!hum_present_q || hf < 34'sd0) begin
			hum_c = '0;
		end else if (hf > HUM_MAX) begin
			hum_c = HUM_MAX[28:12];
		end else begin
			hum_c = hf[28:12];
		end
		side_s7 = '{temp: temp_s7, hum: hum_c, neg: neg_s7, dz: dz_s7, ovf: ovf_s7};
	end

	logic [NUM_MAG_W-1:0] dv_rem_sd  [DIV_STEPS];
	logic [DEN_W-1:0]     dv_den_sd  [DIV_STEPS];
	logic [QUO_W-1:0]     dv_quo_sd  [DIV_STEPS];
	esc_side_t            dv_side_sd [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [NUM_MAG_W-1:0] rem_in;
		logic [DEN_W-1:0]     den_in;
		logic [QUO_W-1:0]     quo_in;
		esc_side_t            side_in;
		logic                 v_in;
		logic [TRIAL_W-1:0]   trial;
		if (j == 0) begin : g_head
			assign rem_in  = n_s7;
			assign den_in  = d_s7;
			assign quo_in  = '0;
			assign side_in = side_s7;
			assign v_in    = v_s7;
		end else begin : g_tail
			assign rem_in  = dv_rem_sd[j-1];
			assign den_in  = dv_den_sd[j-1];
			assign quo_in  = dv_quo_sd[j-1];
			assign side_in = dv_side_sd[j-1];
			assign v_in    = dv_v_sd[j-1];
		end
		assign trial = {{(TRIAL_W-NUM_MAG_W){1'b0}}, rem_in}
			- ({{QUO_W{1'b0}}, den_in} << (DIV_STEPS - 1 - j));
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_sd[j]  <= trial[TRIAL_W-1] ? rem_in : trial[NUM_MAG_W-1:0];
				dv_quo_sd[j]  <= trial[TRIAL_W-1] ? quo_in
					: (quo_in | (QUO_W'(1) << (DIV_STEPS - 1 - j)));
				dv_den_sd[j]  <= den_in;
				dv_side_sd[j] <= side_in;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_sd[j] <= 1'b0;
			end else if (adv) begin
				dv_v_sd[j] <= v_in;
			end
		end
	end

	// Pressure correction after the divide.
	logic [QUO_W-1:0]    qm;
	logic signed [36:0]  pq_s44, pq_s45;
	esc_side_t           side_s44, side_s45, side_s46, side_s47;
	logic signed [23:0]  s13;
	logic signed [47:0]  sq13;
	logic signed [52:0]  c2_prod;
	logic [46:0]         sq13_s45;
	logic signed [33:0]  c2_s45;
	logic signed [63:0]  c1_prod;
	logic signed [40:0]  psum_s46;
	logic signed [33:0]  pf;
	logic [PRESS_W-1:0]  press_c;
	logic [PRESS_W-1:0]  press_s47;
	logic                pvalid_s47;

	always_comb begin
		if (dv_side_sd[DIV_STEPS-1].ovf || dv_quo_sd[DIV_STEPS-1] > QUOT_LIM) begin
			qm = QUOT_LIM;
		end else begin
			qm = dv_quo_sd[DIV_STEPS-1];
		end
	end

	assign s13     = $signed(pq_s44[36:13]);
	assign sq13    = s13 * s13;
	assign c2_prod = p8 * pq_s44;
	assign c1_prod = $signed({1'b0, sq13_s45}) * p9;
	assign pf      = $signed(psum_s46[40:8]) + $signed({p7, 4'b0});

	always_comb begin
		if (side_s46.dz || pf < 34'sd0) begin
			press_c = '0;
		end else if (pf > 34'sh0ffffffff) begin
			press_c = '1;
		end else begin
			press_c = pf[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_va_s1   <= $signed(ta_prod[33:11]);
			td_sq_s1  <= td_sq[31:0];
			raw_p_s1  <= samp.raw_pressure;
			raw_h_s1  <= samp.raw_humidity;

			fine_s2   <= t_va_s1 + $signed(tb_prod[36:14]);
			raw_p_s2  <= raw_p_s1;
			raw_h_s2  <= raw_h_s1;

			temp_s3   <= temp_c;
			pva_sq_s3 <= pva_sq[46:0];
			pv_p5_s3  <= pv_p5;
			pv_p2_s3  <= pv_p2;
			hx_s3     <= $signed(hx_sum[37:15]);
			hy1_s3    <= $signed(hh_h6[31:10]);
			hy2_s3    <= $signed(hh_h3[32:11]) + 23'sd32768;
			raw_p_s3  <= raw_p_s2;

			temp_s4   <= temp_s3;
			pvb_s4    <= pvb_p6 + $signed({pv_p5_s3, 17'b0}) + $signed({p4, 35'b0});
			pa_s4     <= 58'sd140737488355328 + $signed(pva_p3[63:8])
				+ $signed({pv_p2_s3, 12'b0});
			hy_s4     <= $signed(hy_prod[44:10]);
			hx_s4     <= hx_s3;
			raw_p_s4  <= raw_p_s3;

			temp_s5   <= temp_s4;
			pd_s5     <= $signed(pd_prod[74:33]);
			pnum_s5   <= pn_sat;
			hyy_s5    <= $signed(hm[51:14]);
			hx_s5     <= hx_s4;

			temp_s6   <= temp_s5;
			n_s6      <= nm_abs[NUM_MAG_W-1:0];
			d_s6      <= pd_abs[DEN_W-1:0];
			neg_s6    <= nm[64] ^ pd_s5[41];
			dz_s6     <= pd_s5 == 42'sd0;
			hc_s6     <= hc_sat;

			temp_s7   <= temp_s6;
			n_s7      <= n_s6;
			d_s7      <= d_s6;
			neg_s7    <= neg_s6;
			dz_s7     <= dz_s6;
			ovf_s7    <= ovf;
			haa_s7    <= haa[32:0];
			hc_s7     <= hc_s6;

			pq_s44    <= dv_side_sd[DIV_STEPS-1].neg ? -$signed({1'b0, qm})
				: $signed({1'b0, qm});
			side_s44  <= dv_side_sd[DIV_STEPS-1];

			sq13_s45  <= sq13[46:0];
			c2_s45    <= $signed(c2_prod[52:19]);
			pq_s45    <= pq_s44;
			side_s45  <= side_s44;

			psum_s46  <= pq_s45 + $signed(c1_prod[63:25]) + c2_s45;
			side_s46  <= side_s45;

			press_s47  <= press_c;
			pvalid_s47 <= !side_s46.dz;
			side_s47   <= side_s46;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s44 <= 1'b0;
			v_s45 <= 1'b0;
			v_s46 <= 1'b0;
			v_s47 <= 1'b0;
		end else if (adv) begin
			v_s1  <= samp.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s44 <= dv_v_sd[DIV_STEPS-1];
			v_s45 <= v_s44;
			v_s46 <= v_s45;
			v_s47 <= v_s46;
		end
	end

	assign res.valid             = v_s47;
	assign res.temperature_centi = side_s47.temp;
	assign res.pressure_q24_8    = press_s47;
	assign res.pressure_valid    = pvalid_s47;
	assign res.humidity_q22_10   = side_s47.hum;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		samp.valid && samp.ready |=> v_s1)
		else $error("accepted sample word did not enter the first stage");

	a_press_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.pressure_valid |-> res.pressure_q24_8 == '0)
		else $error("pressure not zero with a zero divisor");

	a_hum_absent: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !hum_present_q |-> res.humidity_q22_10 == '0)
		else $error("humidity not zero with the channel absent");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.humidity_q22_10 <= HUM_OUT_MAX)
		else $error("humidity above full scale");

endmodule
